@@ src/sam_pkg.sv @@
// Shared types, constants and helpers for the suffix automaton builder.
package sam_pkg;

  localparam int NODE_CAP    = 2048;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(NODE_CAP);
  localparam int CNT_W       = $clog2(NODE_CAP + 1);
  localparam int TRANS_DEPTH = NODE_CAP * ALPHABET;
  localparam int TA_W        = $clog2(TRANS_DEPTH);
  localparam int J_W         = $clog2(ALPHABET);
  localparam int CL_W        = $clog2(2 * ALPHABET);
  localparam int OP_W        = 3;
  localparam int CH_W        = 7;
  localparam int ST_W        = 2;
  localparam logic [CH_W-1:0] LETTER_BASE = 7'd97;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_SORT   = 3'd2,
    OP_RANK   = 3'd3,
    OP_TRANS  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // One entry of the node attribute memory.
  typedef struct packed {
    logic              end_mark;
    logic [NODE_W-1:0] link;
    logic [NODE_W-1:0] len;
  } node_t;

  // One result transaction.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] node_length;
    logic [NODE_W-1:0] suffix_link;
    logic              end_flag;
    logic [CNT_W-1:0]  node_count;
  } res_t;

  // Address of one transition entry: row of the node, column of the letter.
  function automatic logic [TA_W-1:0] taddr(input logic [NODE_W-1:0] node,
                                            input logic [J_W-1:0] col);
    taddr = TA_W'(node) * TA_W'(ALPHABET) + TA_W'(col);
  endfunction

  // Result that carries only a status and the slot count.
  function automatic res_t res_plain(input status_t st, input logic [CNT_W-1:0] cnt);
    res_t r;
    r            = '0;
    r.status     = st;
    r.node_count = cnt;
    res_plain    = r;
  endfunction

endpackage

@@ src/sam_ifs.sv @@
// Valid/ready channel interfaces for commands and results.
interface sam_in_if;
  logic                      valid;
  logic                      ready;
  logic [sam_pkg::OP_W-1:0]   operation;
  logic [sam_pkg::CH_W-1:0]   char_code;
  logic [sam_pkg::NODE_W-1:0] node_index;
  logic [sam_pkg::NODE_W-1:0] rank_index;
  modport source(output valid, operation, char_code, node_index, rank_index, input ready);
  modport sink(input valid, operation, char_code, node_index, rank_index, output ready);
endinterface

interface sam_out_if;
  logic                      valid;
  logic                      ready;
  logic [sam_pkg::ST_W-1:0]   status;
  logic [sam_pkg::NODE_W-1:0] node_id;
  logic [sam_pkg::NODE_W-1:0] node_length;
  logic [sam_pkg::NODE_W-1:0] suffix_link;
  logic                      end_flag;
  logic [sam_pkg::CNT_W-1:0]  node_count;
  modport source(output valid, status, node_id, node_length, suffix_link, end_flag,
                 node_count, input ready);
  modport sink(input valid, status, node_id, node_length, suffix_link, end_flag,
               node_count, output ready);
endinterface

@@ src/sam_outreg.sv @@
// Output register that holds one result transaction until it is taken.
module sam_outreg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  sam_pkg::res_t res,
  output logic          slot_free,
  output logic          out_valid,
  output sam_pkg::res_t out_data,
  input  logic          out_ready
);

  logic          valid_r, valid_nxt;
  sam_pkg::res_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Load a new result when the slot is empty or drains, otherwise drop valid once taken.
  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && slot_free) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      data_r <= res;
    end
  end

endmodule

@@ src/sam_core.sv @@
// Memory-centered sequencer that builds, sorts and reads the suffix automaton.
module sam_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sam_pkg::OP_W-1:0]   in_operation,
  input  logic [sam_pkg::CH_W-1:0]   in_char_code,
  input  logic [sam_pkg::NODE_W-1:0] in_node_index,
  input  logic [sam_pkg::NODE_W-1:0] in_rank_index,
  output logic                      res_valid,
  output sam_pkg::res_t             res,
  input  logic                      slot_free
);

  localparam int NW = sam_pkg::NODE_W;
  localparam int CW = sam_pkg::CNT_W;
  localparam int JW = sam_pkg::J_W;
  localparam int AW = sam_pkg::TA_W;
  localparam int CH_W_LOCAL = sam_pkg::CH_W;

  typedef enum logic [31:0] {
    S_IDLE   = 32'h0000_0001,
    S_CLEAR  = 32'h0000_0002,
    S_CHK_RD = 32'h0000_0004,
    S_CHK_EV = 32'h0000_0008,
    S_CHK_O  = 32'h0000_0010,
    S_FCHK   = 32'h0000_0020,
    S_LAST   = 32'h0000_0040,
    S_ROWCLR = 32'h0000_0080,
    S_W1_RD  = 32'h0000_0100,
    S_W1_EV  = 32'h0000_0200,
    S_CP_RD  = 32'h0000_0400,
    S_CP_WR  = 32'h0000_0800,
    S_W2_RD  = 32'h0000_1000,
    S_W2_EV  = 32'h0000_2000,
    S_FIN    = 32'h0000_4000,
    S_FIN_K  = 32'h0000_8000,
    S_FIN_O  = 32'h0001_0000,
    S_SB_CLR = 32'h0002_0000,
    S_SC_RD  = 32'h0004_0000,
    S_SC_BK  = 32'h0008_0000,
    S_SC_WR  = 32'h0010_0000,
    S_SP_RD  = 32'h0020_0000,
    S_SP_WR  = 32'h0040_0000,
    S_PL_RD  = 32'h0080_0000,
    S_PL_BK  = 32'h0100_0000,
    S_PL_WR  = 32'h0200_0000,
    S_RK_RD  = 32'h0400_0000,
    S_RK_ND  = 32'h0800_0000,
    S_TR_RD  = 32'h1000_0000,
    S_TR_ND  = 32'h2000_0000,
    S_RPT    = 32'h4000_0000,
    S_DONE   = 32'h8000_0000
  } state_t;

  // Memories.
  logic [NW-1:0]      trans_mem [sam_pkg::TRANS_DEPTH];
  sam_pkg::node_t     node_mem  [sam_pkg::NODE_CAP];
  logic [CW-1:0]      bkt_mem   [sam_pkg::NODE_CAP];
  logic [NW-1:0]      ord_mem   [sam_pkg::NODE_CAP];

  logic               t_we, n_we, b_we, o_we;
  logic [AW-1:0]      t_waddr, t_raddr;
  logic [NW-1:0]      t_wdata, t_rdata;
  logic [NW-1:0]      n_waddr, n_raddr;
  sam_pkg::node_t     n_wdata, n_rdata;
  logic [NW-1:0]      b_waddr, b_raddr;
  logic [CW-1:0]      b_wdata, b_rdata;
  logic [NW-1:0]      o_waddr, o_raddr, o_wdata, o_rdata;

  // Control and working registers.
  state_t             state_r, state_nxt;
  logic               boot_r, boot_nxt;
  logic [sam_pkg::CL_W-1:0] cl_r, cl_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  logic [JW-1:0]      c_r, c_nxt;
  logic [NW-1:0]      node_r, node_nxt, rank_r, rank_nxt;
  logic [CW-1:0]      alloc_r, alloc_nxt, sort_cnt_r, sort_cnt_nxt;
  logic [NW-1:0]      last_r, last_nxt;
  logic [NW-1:0]      v_r, v_nxt, vstop_r, vstop_nxt, o_r, o_nxt;
  logic [NW-1:0]      u_r, u_nxt, k_r, k_nxt, id_r, id_nxt;
  logic [NW-1:0]      len_v_r, len_v_nxt, len_o_r, len_o_nxt, len_u_r, len_u_nxt;
  logic [NW-1:0]      link_o_r, link_o_nxt, len_r, len_nxt;
  logic               end_o_r, end_o_nxt, clone_r, clone_nxt;
  logic [CW-1:0]      i_r, i_nxt, sum_r, sum_nxt;
  sam_pkg::res_t      res_r, res_nxt;

  logic               letter_ok;
  logic [CH_W_LOCAL-1:0] ch_off;
  logic [NW-1:0]      link_u;
  logic [CW:0]        need_sum;
  logic [CW-1:0]      dec;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Letter decode of the incoming transaction.
  assign ch_off    = in_char_code - sam_pkg::LETTER_BASE;
  assign letter_ok = (in_char_code >= sam_pkg::LETTER_BASE) &&
                     (ch_off < CH_W_LOCAL'(sam_pkg::ALPHABET));

  // Suffix link of the new state once the walks are done.
  assign link_u   = (vstop_r == '0) ? NW'(1) : (clone_r ? k_r : o_r);
  assign need_sum = {1'b0, alloc_r} + (clone_r ? (CW+1)'(2) : (CW+1)'(1));
  assign dec      = b_rdata - CW'(1);

  always_comb begin
    state_nxt    = state_r;
    boot_nxt     = boot_r;
    cl_nxt       = cl_r;
    j_nxt        = j_r;
    c_nxt        = c_r;
    node_nxt     = node_r;
    rank_nxt     = rank_r;
    alloc_nxt    = alloc_r;
    sort_cnt_nxt = sort_cnt_r;
    last_nxt     = last_r;
    v_nxt        = v_r;
    vstop_nxt    = vstop_r;
    o_nxt        = o_r;
    u_nxt        = u_r;
    k_nxt        = k_r;
    id_nxt       = id_r;
    len_v_nxt    = len_v_r;
    len_o_nxt    = len_o_r;
    len_u_nxt    = len_u_r;
    link_o_nxt   = link_o_r;
    len_nxt      = len_r;
    end_o_nxt    = end_o_r;
    clone_nxt    = clone_r;
    i_nxt        = i_r;
    sum_nxt      = sum_r;
    res_nxt      = res_r;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;

    case (state_r)
      // Decode a new transaction.
      S_IDLE: begin
        if (in_valid) begin
          c_nxt    = JW'(ch_off);
          node_nxt = in_node_index;
          rank_nxt = in_rank_index;
          case (sam_pkg::op_t'(in_operation))
            sam_pkg::OP_CLEAR: begin
              cl_nxt    = '0;
              state_nxt = S_CLEAR;
            end
            sam_pkg::OP_APPEND: begin
              if (!letter_ok) begin
                res_nxt   = sam_pkg::res_plain(sam_pkg::ST_BAD, alloc_r);
                state_nxt = S_DONE;
              end else begin
                v_nxt     = last_r;
                state_nxt = S_CHK_RD;
              end
            end
            sam_pkg::OP_SORT: begin
              i_nxt     = '0;
              state_nxt = S_SB_CLR;
            end
            sam_pkg::OP_RANK: begin
              if (in_rank_index == '0 || {1'b0, in_rank_index} >= sort_cnt_r) begin
                res_nxt   = sam_pkg::res_plain(sam_pkg::ST_BAD, alloc_r);
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RK_RD;
              end
            end
            sam_pkg::OP_TRANS: begin
              if (!letter_ok || {1'b0, in_node_index} >= alloc_r) begin
                res_nxt   = sam_pkg::res_plain(sam_pkg::ST_BAD, alloc_r);
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_TR_RD;
              end
            end
            default: begin
              res_nxt   = sam_pkg::res_plain(sam_pkg::ST_OK, alloc_r);
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Rewrite the sentinel and the root, one transition entry per cycle.
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = AW'(cl_r);
        t_wdata = '0;
        if (cl_r < sam_pkg::CL_W'(2)) begin
          n_we    = 1'b1;
          n_waddr = NW'(cl_r);
          n_wdata = '0;
        end
        if (cl_r == sam_pkg::CL_W'(2 * sam_pkg::ALPHABET - 1)) begin
          alloc_nxt    = CW'(2);
          last_nxt     = NW'(1);
          sort_cnt_nxt = '0;
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            res_nxt             = sam_pkg::res_plain(sam_pkg::ST_OK, CW'(2));
            res_nxt.node_id     = NW'(1);
            state_nxt           = S_DONE;
          end
        end else begin
          cl_nxt = cl_r + 1'b1;
        end
      end

      // First walk: find where the suffix links meet a transition on the letter.
      S_CHK_RD: begin
        if (v_r == '0) begin
          vstop_nxt = '0;
          clone_nxt = 1'b0;
          state_nxt = S_FCHK;
        end else begin
          t_raddr   = sam_pkg::taddr(v_r, c_r);
          n_raddr   = v_r;
          state_nxt = S_CHK_EV;
        end
      end
      S_CHK_EV: begin
        if (t_rdata == '0) begin
          v_nxt     = n_rdata.link;
          state_nxt = S_CHK_RD;
        end else begin
          vstop_nxt = v_r;
          o_nxt     = t_rdata;
          len_v_nxt = n_rdata.len;
          n_raddr   = t_rdata;
          state_nxt = S_CHK_O;
        end
      end
      S_CHK_O: begin
        len_o_nxt  = n_rdata.len;
        link_o_nxt = n_rdata.link;
        end_o_nxt  = n_rdata.end_mark;
        clone_nxt  = (len_v_r + NW'(1)) != n_rdata.len;
        state_nxt  = S_FCHK;
      end

      // Capacity check, then slot allocation.
      S_FCHK: begin
        if (need_sum > (CW+1)'(sam_pkg::NODE_CAP)) begin
          res_nxt   = sam_pkg::res_plain(sam_pkg::ST_FULL, alloc_r);
          state_nxt = S_DONE;
        end else begin
          u_nxt     = alloc_r[NW-1:0];
          k_nxt     = NW'(alloc_r + CW'(1));
          alloc_nxt = need_sum[CW-1:0];
          v_nxt     = last_r;
          n_raddr   = last_r;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        len_u_nxt = n_rdata.len + NW'(1);
        j_nxt     = '0;
        state_nxt = S_ROWCLR;
      end
      S_ROWCLR: begin
        t_we    = 1'b1;
        t_waddr = sam_pkg::taddr(u_r, j_r);
        t_wdata = '0;
        if (j_r == JW'(sam_pkg::ALPHABET - 1)) begin
          state_nxt = S_W1_RD;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      // Second walk: point missing transitions at the new state.
      S_W1_RD: begin
        if (v_r == vstop_r) begin
          j_nxt     = '0;
          state_nxt = clone_r ? S_CP_RD : S_FIN;
        end else begin
          n_raddr   = v_r;
          state_nxt = S_W1_EV;
        end
      end
      S_W1_EV: begin
        t_we      = 1'b1;
        t_waddr   = sam_pkg::taddr(v_r, c_r);
        t_wdata   = u_r;
        v_nxt     = n_rdata.link;
        state_nxt = S_W1_RD;
      end

      // Copy the transition row of the split state into the clone.
      S_CP_RD: begin
        t_raddr   = sam_pkg::taddr(o_r, j_r);
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        t_we    = 1'b1;
        t_waddr = sam_pkg::taddr(k_r, j_r);
        t_wdata = t_rdata;
        if (j_r == JW'(sam_pkg::ALPHABET - 1)) begin
          v_nxt     = vstop_r;
          state_nxt = S_W2_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_CP_RD;
        end
      end

      // Third walk: redirect transitions from the split state to the clone.
      S_W2_RD: begin
        if (v_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          t_raddr   = sam_pkg::taddr(v_r, c_r);
          n_raddr   = v_r;
          state_nxt = S_W2_EV;
        end
      end
      S_W2_EV: begin
        if (t_rdata == o_r) begin
          t_we      = 1'b1;
          t_waddr   = sam_pkg::taddr(v_r, c_r);
          t_wdata   = k_r;
          v_nxt     = n_rdata.link;
          state_nxt = S_W2_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Write back the attributes of the new state and, for a clone, of the clone and the split state.
      S_FIN: begin
        n_we     = 1'b1;
        n_waddr  = u_r;
        n_wdata  = '{end_mark: 1'b1, link: link_u, len: len_u_r};
        last_nxt = u_r;
        if (clone_r) begin
          state_nxt = S_FIN_K;
        end else begin
          res_nxt   = '{status: sam_pkg::ST_OK, node_id: u_r, node_length: len_u_r,
                        suffix_link: link_u, end_flag: 1'b1, node_count: alloc_r};
          state_nxt = S_DONE;
        end
      end
      S_FIN_K: begin
        n_we      = 1'b1;
        n_waddr   = k_r;
        n_wdata   = '{end_mark: 1'b0, link: link_o_r, len: len_v_r + NW'(1)};
        state_nxt = S_FIN_O;
      end
      S_FIN_O: begin
        n_we      = 1'b1;
        n_waddr   = o_r;
        n_wdata   = '{end_mark: end_o_r, link: k_r, len: len_o_r};
        res_nxt   = '{status: sam_pkg::ST_OK, node_id: u_r, node_length: len_u_r,
                      suffix_link: link_u, end_flag: 1'b1, node_count: alloc_r};
        state_nxt = S_DONE;
      end

      // Counting sort: clear the buckets, the sentinel counts in bucket zero.
      S_SB_CLR: begin
        b_we    = 1'b1;
        b_waddr = i_r[NW-1:0];
        b_wdata = (i_r == '0) ? CW'(1) : '0;
        if (i_r == alloc_r - CW'(1)) begin
          i_nxt     = CW'(1);
          state_nxt = S_SC_RD;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_SC_RD: begin
        n_raddr   = i_r[NW-1:0];
        state_nxt = S_SC_BK;
      end
      S_SC_BK: begin
        b_raddr   = n_rdata.len;
        len_nxt   = n_rdata.len;
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        b_we    = 1'b1;
        b_waddr = len_r;
        b_wdata = b_rdata + CW'(1);
        if (i_r == alloc_r - CW'(1)) begin
          i_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_SP_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SC_RD;
        end
      end

      // Running prefix sum over the buckets.
      S_SP_RD: begin
        b_raddr   = i_r[NW-1:0];
        state_nxt = S_SP_WR;
      end
      S_SP_WR: begin
        sum_nxt = sum_r + b_rdata;
        b_we    = 1'b1;
        b_waddr = i_r[NW-1:0];
        b_wdata = sum_r + b_rdata;
        if (i_r == alloc_r - CW'(1)) begin
          state_nxt = S_PL_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SP_RD;
        end
      end

      // Place the states from the highest slot down.
      S_PL_RD: begin
        n_raddr   = i_r[NW-1:0];
        state_nxt = S_PL_BK;
      end
      S_PL_BK: begin
        b_raddr   = n_rdata.len;
        len_nxt   = n_rdata.len;
        state_nxt = S_PL_WR;
      end
      S_PL_WR: begin
        b_we    = 1'b1;
        b_waddr = len_r;
        b_wdata = dec;
        o_we    = 1'b1;
        o_waddr = dec[NW-1:0];
        o_wdata = i_r[NW-1:0];
        if (i_r == CW'(1)) begin
          sort_cnt_nxt = alloc_r;
          res_nxt      = sam_pkg::res_plain(sam_pkg::ST_OK, alloc_r);
          state_nxt    = S_DONE;
        end else begin
          i_nxt     = i_r - CW'(1);
          state_nxt = S_PL_RD;
        end
      end

      // Rank and transition reads, then the node attribute fetch.
      S_RK_RD: begin
        o_raddr   = rank_r;
        state_nxt = S_RK_ND;
      end
      S_RK_ND: begin
        n_raddr   = o_rdata;
        id_nxt    = o_rdata;
        state_nxt = S_RPT;
      end
      S_TR_RD: begin
        t_raddr   = sam_pkg::taddr(node_r, c_r);
        state_nxt = S_TR_ND;
      end
      S_TR_ND: begin
        n_raddr   = t_rdata;
        id_nxt    = t_rdata;
        state_nxt = S_RPT;
      end
      S_RPT: begin
        res_nxt   = '{status: sam_pkg::ST_OK, node_id: id_r, node_length: n_rdata.len,
                      suffix_link: n_rdata.link, end_flag: n_rdata.end_mark,
                      node_count: alloc_r};
        state_nxt = S_DONE;
      end

      // Hand the result to the output register.
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      boot_r     <= 1'b1;
      cl_r       <= '0;
      alloc_r    <= CW'(2);
      last_r     <= NW'(1);
      sort_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      boot_r     <= boot_nxt;
      cl_r       <= cl_nxt;
      alloc_r    <= alloc_nxt;
      last_r     <= last_nxt;
      sort_cnt_r <= sort_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    c_r      <= c_nxt;
    node_r   <= node_nxt;
    rank_r   <= rank_nxt;
    v_r      <= v_nxt;
    vstop_r  <= vstop_nxt;
    o_r      <= o_nxt;
    u_r      <= u_nxt;
    k_r      <= k_nxt;
    id_r     <= id_nxt;
    len_v_r  <= len_v_nxt;
    len_o_r  <= len_o_nxt;
    len_u_r  <= len_u_nxt;
    link_o_r <= link_o_nxt;
    len_r    <= len_nxt;
    end_o_r  <= end_o_nxt;
    clone_r  <= clone_nxt;
    i_r      <= i_nxt;
    sum_r    <= sum_nxt;
    res_r    <= res_nxt;
  end

  // Transition memory.
  always_ff @(posedge clk) begin
    if (t_we) begin
      trans_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= trans_mem[t_raddr];
  end

  // Node attribute memory.
  always_ff @(posedge clk) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    n_rdata <= node_mem[n_raddr];
  end

  // Bucket count memory.
  always_ff @(posedge clk) begin
    if (b_we) begin
      bkt_mem[b_waddr] <= b_wdata;
    end
    b_rdata <= bkt_mem[b_raddr];
  end

  // Sorted order memory.
  always_ff @(posedge clk) begin
    if (o_we) begin
      ord_mem[o_waddr] <= o_wdata;
    end
    o_rdata <= ord_mem[o_raddr];
  end

endmodule

@@ src/suffix_automaton_builder_unit.sv @@
// Clear rewrites the sentinel and the root; append walks the suffix links, with a row copy for a clone.
// Sort passes over every allocated slot; rank and transition reads fetch one entry and then a node.
// One transaction is worked at a time, paced by the transition and node memories.
// A result waits in an output register while the next transaction is accepted.
// After reset a pass writes the sentinel and the root, with in_ch.ready low.
// Reset is synchronous and active low; the memories themselves are not cleared.
module suffix_automaton_builder_unit (
  input logic        clk,
  input logic        rst_n,
  sam_in_if.sink     in_ch,
  sam_out_if.source  out_ch
);

  logic          res_valid;
  logic          slot_free;
  sam_pkg::res_t res;
  sam_pkg::res_t out_data;

  // Sequencer with the automaton memories.
  sam_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_operation  (in_ch.operation),
    .in_char_code  (in_ch.char_code),
    .in_node_index (in_ch.node_index),
    .in_rank_index (in_ch.rank_index),
    .res_valid     (res_valid),
    .res           (res),
    .slot_free     (slot_free)
  );

  // Result register.
  sam_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .out_ready (out_ch.ready)
  );

  assign out_ch.status      = out_data.status;
  assign out_ch.node_id     = out_data.node_id;
  assign out_ch.node_length = out_data.node_length;
  assign out_ch.suffix_link = out_data.suffix_link;
  assign out_ch.end_flag    = out_data.end_flag;
  assign out_ch.node_count  = out_data.node_count;

endmodule
